// ===== sv/ptd_pkg.sv =====
// ptd_pkg: shared constants, types and channel expansion functions for the
// paletted texel decoder; no dependencies, compiled first
`default_nettype none

package ptd_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_IDX_W     = $clog2(PALETTE_DEPTH);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int PIX_CNT_W     = 2;
    localparam int APB_ADDR_W    = 3;
    localparam int REG_IDX_BIT   = 2;

    // reciprocals for the divide-by-31 and divide-by-7 in the expansions
    localparam logic [16:0] EXP5_RECIP = 17'd33826;
    localparam logic [13:0] EXP3_RECIP = 14'd9363;

    localparam logic CMD_PAL_WRITE = 1'b0;
    localparam logic CMD_TEXEL     = 1'b1;

    localparam logic REG_TEX_FMT = 1'b0;
    localparam logic REG_COLOR0  = 1'b1;

    typedef enum logic [2:0] {
        FMT_A3I5   = 3'd0,
        FMT_A5I3   = 3'd1,
        FMT_PAL2   = 3'd2,
        FMT_PAL4   = 3'd3,
        FMT_PAL8   = 3'd4,
        FMT_DIRECT = 3'd5
    } tex_fmt_t;

    typedef enum logic [1:0] {
        ALPHA_PAL    = 2'd0,
        ALPHA_A3     = 2'd1,
        ALPHA_A5     = 2'd2,
        ALPHA_DIRECT = 2'd3
    } alpha_mode_t;

    // one queued request between front and back
    typedef struct packed {
        logic                 is_write;
        tex_fmt_t             fmt;
        logic                 clear0;
        logic [7:0]           pal_index;
        logic [14:0]          pal_color;
        logic [15:0]          texel_data;
        logic                 last;
        logic [PIX_CNT_W-1:0] npix_m1;
    } entry_t;

    // one pixel after palette lookup, before channel expansion
    typedef struct packed {
        logic        valid;
        alpha_mode_t mode;
        logic        loaded;
        logic [14:0] color;
        logic [4:0]  alpha_raw;
        logic [15:0] direct_word;
        logic        run_last;
        logic        frame_last;
    } pix_t;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [12:0] x;
        logic [29:0] p;
        x = 13'(v) * 13'd255 + 13'd15;
        p = 30'(x) * 30'(EXP5_RECIP);
        return p[27:20];
    endfunction

    function automatic logic [7:0] expand3(input logic [2:0] v);
        logic [10:0] x;
        logic [23:0] p;
        x = 11'(v) * 11'd255 + 11'd3;
        p = 24'(x) * 24'(EXP3_RECIP);
        return p[23:16];
    endfunction

endpackage

`default_nettype wire

// ===== sv/ptd_if.sv =====
// ptd_if: valid/ready channel interfaces for input requests and output pixels
// no dependencies
`default_nettype none

interface ptd_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  pal_index;
    logic [14:0] pal_color;
    logic [15:0] texel_data;
    logic        texel_last;

    modport source (output valid, cmd, pal_index, pal_color, texel_data, texel_last,
                    input ready);
    modport sink (input valid, cmd, pal_index, pal_color, texel_data, texel_last,
                  output ready);
endinterface

interface ptd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;
    logic       run_last;
    logic       frame_last;

    modport source (output valid, red, green, blue, alpha_out, run_last, frame_last,
                    input ready);
    modport sink (input valid, red, green, blue, alpha_out, run_last, frame_last,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/ptd_front.sv =====
// ptd_front: config registers, request intake and classification into queue entries
// depends on ptd_pkg and ptd_in_if
`default_nettype none

module ptd_front (
    input  logic                           clk,
    input  logic                           rst_n,
    ptd_in_if.sink                         items,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ptd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           full,
    output logic                           push,
    output ptd_pkg::entry_t                push_entry
);
    import ptd_pkg::*;

    logic [2:0] fmt_reg;
    logic       clear0_reg;
    logic       cfg_wr;
    logic       fmt_ok;
    logic       is_write;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= 3'(FMT_A3I5);
            clear0_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[REG_IDX_BIT])
                REG_TEX_FMT: fmt_reg    <= pwdata[2:0];
                REG_COLOR0:  clear0_reg <= pwdata[0];
                default:     fmt_reg    <= fmt_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[REG_IDX_BIT])
            REG_TEX_FMT: prdata = {29'd0, fmt_reg};
            REG_COLOR0:  prdata = {31'd0, clear0_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // texels under an undefined format are taken and dropped
    assign fmt_ok   = fmt_reg <= 3'(FMT_DIRECT);
    assign is_write = items.cmd == CMD_PAL_WRITE;

    assign items.ready = !full;
    assign push        = items.valid && !full && (is_write || fmt_ok);

    always_comb
    begin
        push_entry            = '0;
        push_entry.is_write   = is_write;
        push_entry.fmt        = tex_fmt_t'(fmt_reg);
        push_entry.clear0     = clear0_reg;
        push_entry.pal_index  = items.pal_index;
        push_entry.pal_color  = items.pal_color;
        push_entry.texel_data = items.texel_data;
        push_entry.last       = items.texel_last;
        case (fmt_reg)
            FMT_PAL2: push_entry.npix_m1 = PIX_CNT_W'(3);
            FMT_PAL4: push_entry.npix_m1 = PIX_CNT_W'(1);
            default:  push_entry.npix_m1 = '0;
        endcase
        if (is_write)
        begin
            push_entry.npix_m1 = '0;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ptd_fifo.sv =====
// ptd_fifo: short request queue between front and back
// depends on ptd_pkg
`default_nettype none

module ptd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ptd_pkg::entry_t push_entry,
    input  logic            pop,
    output ptd_pkg::entry_t head,
    output logic            empty,
    output logic            full
);
    import ptd_pkg::*;

    entry_t                 slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign empty = count_reg == '0;
    assign full  = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ptd_back.sv =====
// ptd_back: pixel sequencer, palette store with loaded bits, and lookup stage
// depends on ptd_pkg
`default_nettype none

module ptd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ptd_pkg::entry_t head,
    input  logic            empty,
    output logic            pop,
    input  logic            adv,
    output ptd_pkg::pix_t   s1
);
    import ptd_pkg::*;

    logic [14:0]          pal_mem [PALETTE_DEPTH];
    logic                 loaded_reg [PALETTE_DEPTH];
    logic [14:0]          color_reg;
    logic [PIX_CNT_W-1:0] k_reg;
    logic [PIX_CNT_W-1:0] k_next;
    logic                 s1_valid_reg;
    alpha_mode_t          mode_reg;
    logic                 hit_reg;
    logic [4:0]           alpha_raw_reg;
    logic [15:0]          direct_reg;
    logic                 run_last_reg;
    logic                 frame_last_reg;

    logic [7:0]           tbyte;
    logic [7:0]           sh2;
    logic [7:0]           sh4;
    logic [7:0]           rd_idx;
    logic                 rd_in_range;
    logic                 wr_in_range;
    logic                 allow_clear;
    logic                 clear_hit;
    alpha_mode_t          mode;
    logic [4:0]           alpha_raw;
    logic                 wr_en;
    logic                 issue;
    logic                 last_pix;

    assign tbyte = head.texel_data[7:0];
    assign sh2   = tbyte >> {k_reg, 1'b0};
    assign sh4   = tbyte >> {k_reg[0], 2'b00};

    always_comb
    begin
        rd_idx      = tbyte;
        mode        = ALPHA_PAL;
        alpha_raw   = '0;
        allow_clear = 1'b1;
        case (head.fmt)
            FMT_A3I5:
            begin
                rd_idx      = {3'd0, tbyte[4:0]};
                mode        = ALPHA_A3;
                alpha_raw   = {2'd0, tbyte[7:5]};
                allow_clear = 1'b0;
            end
            FMT_A5I3:
            begin
                rd_idx      = {5'd0, tbyte[2:0]};
                mode        = ALPHA_A5;
                alpha_raw   = tbyte[7:3];
                allow_clear = 1'b0;
            end
            FMT_PAL2: rd_idx = {6'd0, sh2[1:0]};
            FMT_PAL4: rd_idx = {4'd0, sh4[3:0]};
            FMT_PAL8: rd_idx = tbyte;
            FMT_DIRECT:
            begin
                mode        = ALPHA_DIRECT;
                allow_clear = 1'b0;
            end
            default: rd_idx = tbyte;
        endcase
    end

    assign rd_in_range = {1'b0, rd_idx} < 9'(PALETTE_DEPTH);
    assign wr_in_range = {1'b0, head.pal_index} < 9'(PALETTE_DEPTH);
    assign clear_hit   = allow_clear && head.clear0 && (rd_idx == 8'd0);

    // a write pops even in a stall; a texel holds the head until its last pixel
    assign last_pix = k_reg == head.npix_m1;
    assign wr_en    = !empty && head.is_write;
    assign issue    = !empty && !head.is_write && adv;
    assign pop      = wr_en || (issue && last_pix);

    always_comb
    begin
        k_next = k_reg;
        if (issue)
        begin
            k_next = last_pix ? '0 : k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < PALETTE_DEPTH; i++)
            begin
                loaded_reg[i] <= 1'b0;
            end
        end
        else
        begin
            k_reg <= k_next;
            if (adv)
            begin
                s1_valid_reg <= issue;
            end
            if (wr_en && wr_in_range)
            begin
                loaded_reg[head.pal_index[PAL_IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            pal_mem[head.pal_index[PAL_IDX_W-1:0]] <= head.pal_color;
        end
        if (issue)
        begin
            color_reg <= pal_mem[rd_idx[PAL_IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            mode_reg       <= mode;
            hit_reg        <= rd_in_range && loaded_reg[rd_idx[PAL_IDX_W-1:0]] && !clear_hit;
            alpha_raw_reg  <= alpha_raw;
            direct_reg     <= head.texel_data;
            run_last_reg   <= last_pix;
            frame_last_reg <= last_pix && head.last;
        end
    end

    always_comb
    begin
        s1.valid       = s1_valid_reg;
        s1.mode        = mode_reg;
        s1.loaded      = hit_reg;
        s1.color       = color_reg;
        s1.alpha_raw   = alpha_raw_reg;
        s1.direct_word = direct_reg;
        s1.run_last    = run_last_reg;
        s1.frame_last  = frame_last_reg;
    end

endmodule

`default_nettype wire

// ===== sv/ptd_shade.sv =====
// ptd_shade: channel expansion to RGBA8 and the output register
// depends on ptd_pkg and ptd_out_if
`default_nettype none

module ptd_shade (
    input  logic          clk,
    input  logic          rst_n,
    input  ptd_pkg::pix_t s1,
    output logic          adv,
    ptd_out_if.source     pixels
);
    import ptd_pkg::*;

    logic        out_valid_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic [7:0]  alpha_reg;
    logic        run_last_reg;
    logic        frame_last_reg;

    logic [14:0] src;
    logic        rgb_on;
    logic [7:0]  red_v;
    logic [7:0]  green_v;
    logic [7:0]  blue_v;
    logic [7:0]  alpha_v;

    assign adv = !out_valid_reg || pixels.ready;

    assign src    = (s1.mode == ALPHA_DIRECT) ? s1.direct_word[14:0] : s1.color;
    assign rgb_on = (s1.mode == ALPHA_DIRECT) || s1.loaded;

    always_comb
    begin
        red_v   = rgb_on ? expand5(src[4:0])   : 8'd0;
        green_v = rgb_on ? expand5(src[9:5])   : 8'd0;
        blue_v  = rgb_on ? expand5(src[14:10]) : 8'd0;
        case (s1.mode)
            ALPHA_PAL:    alpha_v = s1.loaded ? 8'd255 : 8'd0;
            ALPHA_A3:     alpha_v = expand3(s1.alpha_raw[2:0]);
            ALPHA_A5:     alpha_v = expand5(s1.alpha_raw);
            ALPHA_DIRECT: alpha_v = s1.direct_word[15] ? 8'd255 : 8'd0;
            default:      alpha_v = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1.valid)
        begin
            red_reg        <= red_v;
            green_reg      <= green_v;
            blue_reg       <= blue_v;
            alpha_reg      <= alpha_v;
            run_last_reg   <= s1.run_last;
            frame_last_reg <= s1.frame_last;
        end
    end

    assign pixels.valid      = out_valid_reg;
    assign pixels.red        = red_reg;
    assign pixels.green      = green_reg;
    assign pixels.blue       = blue_reg;
    assign pixels.alpha_out  = alpha_reg;
    assign pixels.run_last   = run_last_reg;
    assign pixels.frame_last = frame_last_reg;

endmodule

`default_nettype wire

// ===== sv/paletted_texel_decoder.sv =====
// paletted_texel_decoder: a texel passes the queue, lookup registers and output register;
// back to back, one pixel per cycle while the receiver is ready (a two-bit palette byte
// yields 4 pixels, a four-bit byte 2, other formats 1); a palette write retires without
// waiting on the output. A 4-entry queue decouples intake from the pixel sequencer.
// Reset clears config, queue, pipeline valids and all palette loaded bits at once.
`default_nettype none

module paletted_texel_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    ptd_in_if.sink                         items,
    ptd_out_if.source                      pixels,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ptd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import ptd_pkg::*;

    entry_t push_entry;
    entry_t head;
    pix_t   s1;
    logic   push;
    logic   pop;
    logic   empty;
    logic   full;
    logic   adv;

    ptd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    ptd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    ptd_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .adv   (adv),
        .s1    (s1)
    );

    ptd_shade u_shade (
        .clk    (clk),
        .rst_n  (rst_n),
        .s1     (s1),
        .adv    (adv),
        .pixels (pixels)
    );

endmodule

`default_nettype wire

// ===== bench/tb_paletted_texel_decoder.sv =====
// tb_paletted_texel_decoder: self-checking bench for the paletted texel decoder, a directed
// table followed by random phases checked against a built-in pixel predictor
// depends on ptd_pkg, ptd_if and paletted_texel_decoder

module tb_paletted_texel_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import ptd_pkg::*;

    localparam int RANDOM_ITEMS = 320;
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_PRINTED  = 40;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       run_last;
        logic       frame_last;
    } pixel_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // one line of the directed table; a config row uses idx as register and color as value
    typedef struct packed {
        row_kind_t   kind;
        logic        cmd;
        logic [7:0]  idx;
        logic [14:0] color;
        logic [15:0] data;
        logic        last;
        logic        known;
        pixel_t      px;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ptd_in_if  items_if();
    ptd_out_if pixels_if();

    paletted_texel_decoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .pixels  (pixels_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // shadow of the block state
    logic [15:0] pal_shadow [PALETTE_DEPTH];
    logic [2:0]  tex_fmt;
    logic        clear0;

    pixel_t pending_pixels[$];
    int     mismatch_count = 0;
    int     pixels_seen = 0;
    int     burst_left = 0;
    logic   no_idle = 1'b0;

    // receiver stall pattern
    logic [15:0] rx_mask = 16'hFFFF;
    int          rx_pos = 0;
    int          rx_hold = 0;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return 8'((int'(v) * 255 + 15) / 31);
    endfunction

    function automatic logic [7:0] widen3(input logic [2:0] v);
        return 8'((int'(v) * 255 + 3) / 7);
    endfunction

    function automatic void queue_pixel(input pixel_t p);
        pending_pixels.insert(pending_pixels.size(), p);
    endfunction

    function automatic pixel_t bgr_to_pixel(input logic [14:0] bgr);
        pixel_t p;
        p = '0;
        p.red   = widen5(bgr[4:0]);
        p.green = widen5(bgr[9:5]);
        p.blue  = widen5(bgr[14:10]);
        return p;
    endfunction

    function automatic pixel_t palette_color(input logic [7:0] idx, input logic allow_clear);
        logic [15:0] entry;
        pixel_t      p;
        entry = pal_shadow[idx];
        p = '0;
        if (entry[15] && !(allow_clear && idx == 8'd0 && clear0))
        begin
            p = bgr_to_pixel(entry[14:0]);
            p.alpha = 8'd255;
        end
        return p;
    endfunction

    // expected pixels of one texel request, in output order
    function automatic void decode_texel(input logic [15:0] data, input logic last);
        pixel_t     px [4];
        logic [7:0] b;
        int         n;
        b = data[7:0];
        n = 0;
        case (tex_fmt)
            FMT_A3I5:
            begin
                px[0] = palette_color({3'd0, b[4:0]}, 1'b0);
                px[0].alpha = widen3(b[7:5]);
                n = 1;
            end
            FMT_A5I3:
            begin
                px[0] = palette_color({5'd0, b[2:0]}, 1'b0);
                px[0].alpha = widen5(b[7:3]);
                n = 1;
            end
            FMT_PAL2:
            begin
                for (int k = 0; k < 4; k++)
                    px[k] = palette_color({6'd0, b[2*k +: 2]}, 1'b1);
                n = 4;
            end
            FMT_PAL4:
            begin
                for (int k = 0; k < 2; k++)
                    px[k] = palette_color({4'd0, b[4*k +: 4]}, 1'b1);
                n = 2;
            end
            FMT_PAL8:
            begin
                px[0] = palette_color(b, 1'b1);
                n = 1;
            end
            FMT_DIRECT:
            begin
                px[0] = bgr_to_pixel(data[14:0]);
                px[0].alpha = data[15] ? 8'd255 : 8'd0;
                n = 1;
            end
            default:
                n = 0;
        endcase
        for (int k = 0; k < n; k++)
        begin
            px[k].run_last   = (k == n - 1);
            px[k].frame_last = (k == n - 1) && last;
            queue_pixel(px[k]);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("pixel %0d %s got %0d expected %0d",
                                      pixels_seen, name, got, want));
    endtask

    // pixel checker
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n === 1'b1 && pixels_if.valid && pixels_if.ready)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch($sformatf("pixel %0d arrived with nothing pending", pixels_seen));
            else
            begin
                want = pending_pixels.pop_front();
                check_field("red", pixels_if.red, want.red);
                check_field("green", pixels_if.green, want.green);
                check_field("blue", pixels_if.blue, want.blue);
                check_field("alpha_out", pixels_if.alpha_out, want.alpha);
                check_field("run_last", pixels_if.run_last, want.run_last);
                check_field("frame_last", pixels_if.frame_last, want.frame_last);
            end
            pixels_seen++;
        end
    end

    // receiver: rotating ready mask, swapped after a random hold
    always @(negedge clk)
    begin
        if (rx_hold == 0)
        begin
            rx_hold = $urandom_range(32, 200);
            if ($urandom_range(0, 3) == 0)
                rx_mask = 16'hFFFF;
            else
                rx_mask = 16'($urandom) | 16'h0001;
        end
        rx_hold--;
        pixels_if.ready <= rx_mask[rx_pos % 16];
        rx_pos++;
    end

    task automatic apb_write(input logic reg_idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (reg_idx == REG_TEX_FMT)
            tex_fmt = value[2:0];
        else
            clear0 = value[0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait until every pixel is out and palette writes have retired
    task automatic settle();
        @(negedge clk);
        items_if.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(input logic cmd, input logic [7:0] idx, input logic [14:0] color,
                             input logic [15:0] data, input logic last,
                             input logic known, input pixel_t known_px);
        int gap;
        if (burst_left == 0)
        begin
            gap = no_idle ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                @(negedge clk);
                items_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        items_if.valid      <= 1'b1;
        items_if.cmd        <= cmd;
        items_if.pal_index  <= idx;
        items_if.pal_color  <= color;
        items_if.texel_data <= data;
        items_if.texel_last <= last;
        do
            @(posedge clk);
        while (!items_if.ready);
        if (cmd == CMD_PAL_WRITE)
            pal_shadow[idx] = {1'b1, color};
        else if (known)
            queue_pixel(known_px);
        else
            decode_texel(data, last);
    endtask

    function automatic row_t cfg_row(input logic reg_idx, input logic [2:0] value);
        row_t r;
        r = '0;
        r.kind  = ROW_CFG;
        r.idx   = {7'd0, reg_idx};
        r.color = 15'(value);
        return r;
    endfunction

    function automatic row_t pal_row(input logic [7:0] idx, input logic [14:0] color);
        row_t r;
        r = '0;
        r.kind  = ROW_ITEM;
        r.cmd   = CMD_PAL_WRITE;
        r.idx   = idx;
        r.color = color;
        r.data  = 16'hA55A;
        return r;
    endfunction

    function automatic row_t texel_row(input logic [15:0] data, input logic last);
        row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.cmd  = CMD_TEXEL;
        r.data = data;
        r.last = last;
        return r;
    endfunction

    function automatic row_t texel_known(input logic [15:0] data, input logic last,
                                         input logic [7:0] red, input logic [7:0] green,
                                         input logic [7:0] blue, input logic [7:0] alpha);
        row_t r;
        r = texel_row(data, last);
        r.known = 1'b1;
        r.px = '{red: red, green: green, blue: blue, alpha: alpha,
                 run_last: 1'b1, frame_last: last};
        return r;
    endfunction

    row_t directed[$];

    function automatic void add_row(input row_t r);
        directed.insert(directed.size(), r);
    endfunction

    initial
    begin
        logic        cmd;
        logic [7:0]  idx;
        logic [14:0] color;
        logic [15:0] data;
        logic        last;
        logic [2:0]  fmt_pick;
        int          items_done;
        int          phase_len;

        items_if.valid      = 1'b0;
        items_if.cmd        = CMD_PAL_WRITE;
        items_if.pal_index  = '0;
        items_if.pal_color  = '0;
        items_if.texel_data = '0;
        items_if.texel_last = 1'b0;
        pixels_if.ready     = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        foreach (pal_shadow[i])
            pal_shadow[i] = '0;
        tex_fmt = FMT_A3I5;
        clear0  = 1'b0;

        // untouched palette after reset, then extremes of every format
        add_row(texel_known(16'hFFFF, 1'b1, 8'd0, 8'd0, 8'd0, 8'd255));
        add_row(texel_known(16'h0000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0));
        add_row(pal_row(8'd0, 15'h7FFF));
        add_row(pal_row(8'd255, 15'h0000));
        add_row(pal_row(8'd31, 15'h001F));
        add_row(pal_row(8'd7, 15'h7C00));
        add_row(texel_known(16'h001F, 1'b0, 8'd255, 8'd0, 8'd0, 8'd0));
        add_row(texel_known(16'h00E0, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255));
        // entry zero stays opaque in the alpha formats
        add_row(cfg_row(REG_COLOR0, 3'd1));
        add_row(texel_known(16'h00E0, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255));
        add_row(cfg_row(REG_TEX_FMT, FMT_A5I3));
        add_row(texel_known(16'h00FF, 1'b1, 8'd0, 8'd0, 8'd255, 8'd255));
        add_row(texel_known(16'h0007, 1'b0, 8'd0, 8'd0, 8'd255, 8'd0));
        add_row(cfg_row(REG_TEX_FMT, FMT_PAL2));
        add_row(texel_row(16'h00E4, 1'b0));
        add_row(pal_row(8'd1, 15'h03E0));
        add_row(texel_row(16'hFF1B, 1'b1));
        add_row(cfg_row(REG_TEX_FMT, FMT_PAL4));
        add_row(texel_row(16'h00F0, 1'b1));
        add_row(cfg_row(REG_COLOR0, 3'd0));
        add_row(texel_row(16'h000F, 1'b0));
        add_row(cfg_row(REG_TEX_FMT, FMT_PAL8));
        add_row(texel_known(16'h00FF, 1'b0, 8'd0, 8'd0, 8'd0, 8'd255));
        add_row(texel_known(16'h0080, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0));
        add_row(texel_known(16'h0000, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255));
        add_row(cfg_row(REG_TEX_FMT, FMT_DIRECT));
        add_row(texel_known(16'hFFFF, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255));
        add_row(texel_known(16'h0000, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0));
        add_row(texel_known(16'h8000, 1'b0, 8'd0, 8'd0, 8'd0, 8'd255));
        add_row(texel_known(16'h7FFF, 1'b0, 8'd255, 8'd255, 8'd255, 8'd0));
        // undefined format: texels vanish, last flag included
        add_row(cfg_row(REG_TEX_FMT, 3'd7));
        add_row(texel_row(16'h1234, 1'b1));
        add_row(texel_row(16'hFFFF, 1'b0));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                settle();
                apb_write(directed[i].idx[0], 32'(directed[i].color));
            end
            else
                send_item(directed[i].cmd, directed[i].idx, directed[i].color,
                          directed[i].data, directed[i].last, directed[i].known,
                          directed[i].px);
        end

        // random phases, each under one register setting
        items_done = 0;
        while (items_done < RANDOM_ITEMS)
        begin
            settle();
            if ($urandom_range(0, 11) == 0)
                fmt_pick = 3'($urandom_range(6, 7));
            else
                fmt_pick = 3'($urandom_range(FMT_A3I5, FMT_DIRECT));
            apb_write(REG_TEX_FMT, 32'(fmt_pick));
            apb_write(REG_COLOR0, 32'($urandom_range(0, 1)));
            no_idle = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            phase_len = $urandom_range(8, 40);
            for (int n = 0; n < phase_len; n++)
            begin
                cmd   = ($urandom_range(0, 99) < 28) ? CMD_PAL_WRITE : CMD_TEXEL;
                idx   = $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom);
                color = 15'($urandom);
                if ($urandom_range(0, 9) == 0)
                    color = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
                data  = 16'($urandom);
                if (tex_fmt == FMT_PAL8 && $urandom_range(0, 1))
                    data[7:0] = 8'($urandom_range(0, 31));
                last  = ($urandom_range(0, 7) == 0);
                send_item(cmd, idx, color, data, last, 1'b0, '0);
                if (cmd == CMD_PAL_WRITE || tex_fmt <= FMT_DIRECT)
                    items_done++;
            end
        end

        @(negedge clk);
        items_if.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d pixels pending", pending_pixels.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
